// ----- sv/bmf2d_pkg.sv -----
// bmf2d_pkg: shared constants, register indexes, command codes and
// configuration helpers for the 2-D box mean filter.
// Used by box_mean_filter_2d and bmf2d_checker.
package bmf2d_pkg;

	// sizing of the block
	localparam int MAX_KERNEL = 7;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// field widths fixed by the interface
	localparam int KSIZE_W  = 3;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int CFG_W    = 13;
	localparam int CIDX_W   = 2;
	localparam int PIX_W    = 8;
	localparam int MEAN_W   = 16;

	// line store: a ring of rows covering the window plus the rows the input
	// runs ahead of it, up to three radii plus one on a one-pixel-wide image
	localparam int RING_ROWS = 1 << $clog2(3 * (MAX_KERNEL / 2) + 1);
	localparam int RING_W    = $clog2(RING_ROWS);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W    = RING_W + COL_W;
	localparam int MEM_DEPTH = RING_ROWS << COL_W;

	// window arithmetic
	localparam int R_W    = $clog2(MAX_KERNEL / 2 + 1);
	localparam int LAG_W  = $clog2((MAX_KERNEL / 2) * (MAX_WIDTH + 1) + 1);
	localparam int N_W    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int SUM_W  = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
	localparam int NUM_W  = SUM_W + 8;
	localparam int DCNT_W = $clog2(NUM_W);
	localparam int KMAX_I = MAX_KERNEL - 1 + (MAX_KERNEL % 2);

	// largest legal mean, 255.0 in Q8.8
	localparam logic [MEAN_W-1:0] MEAN_MAX = 16'hFF00;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_KERNEL_SIZE  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// reset values of the registers
	localparam logic [KSIZE_W-1:0]  KSIZE_RST  = 3'd3;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd1024;

	// odd window diameter actually used
	function automatic logic [KSIZE_W-1:0] eff_kernel(input logic [KSIZE_W-1:0] k);
		logic [KSIZE_W-1:0] v;
		v = k;
		if (v == '0) v = KSIZE_W'(1);
		if (!v[0]) v = v - KSIZE_W'(1);
		if (int'(v) > KMAX_I) v = KSIZE_W'(KMAX_I);
		return v;
	endfunction

	// row length clamped to 1..MAX_WIDTH
	function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] v;
		v = w;
		if (v == '0) v = WIDTH_W'(1);
		if (int'(v) > MAX_WIDTH) v = WIDTH_W'(MAX_WIDTH);
		return v;
	endfunction

	// frame height clamped to 1..MAX_HEIGHT
	function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] h);
		logic [HEIGHT_W-1:0] v;
		v = h;
		if (v == '0) v = HEIGHT_W'(1);
		if (int'(v) > MAX_HEIGHT) v = HEIGHT_W'(MAX_HEIGHT);
		return v;
	endfunction

endpackage

// ----- sv/box_mean_filter_2d.sv -----
// box_mean_filter_2d: streaming K x K zero-padded box mean over an 8-bit raster image.
// Holds the line store memory, window read sequencer and bit-serial divider.
// Depends on bmf2d_pkg.
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, command, pixel_value  | one pixel or one flush tick
//  out     | out_valid, out_ready, mean_q8, frame_end  | one window mean, Q8.8
//  cfg     | cfg_write_en, cfg_index, cfg_data         | one register write, no wait
//
// A word that yields no result is taken without leaving idle, and in_ready stays high.
// A word that yields a result drops in_ready until the block is idle again:
// one line-store read per window tap, an accumulate step,
// 22 divider steps, the load of the output register and the idle state
// that takes the next word.
// The output register holds a mean until taken; a stalled output holds the
// block in its load state. No clearing pass after reset: the line store is
// only read where the current frame has written it.
module box_mean_filter_2d (
	input  logic                             clk,
	input  logic                             arst_n,
	// input words
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             command,
	input  logic [bmf2d_pkg::PIX_W-1:0]      pixel_value,
	// output words
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bmf2d_pkg::MEAN_W-1:0]     mean_q8,
	output logic                             frame_end,
	// configuration
	input  logic                             cfg_write_en,
	input  logic [bmf2d_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [bmf2d_pkg::CFG_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_ACC,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [bmf2d_pkg::KSIZE_W-1:0]  kernel_size_q;
	logic [bmf2d_pkg::WIDTH_W-1:0]  image_width_q;
	logic [bmf2d_pkg::HEIGHT_W-1:0] image_height_q;

	// frame position
	logic [bmf2d_pkg::ROW_W-1:0] irow_q, orow_q;
	logic [bmf2d_pkg::COL_W-1:0] icol_q, ocol_q;
	logic [bmf2d_pkg::LAG_W-1:0] lead_q;
	logic                        done_q;

	// position of the mean being computed
	logic [bmf2d_pkg::ROW_W-1:0]   erow_q;
	logic [bmf2d_pkg::COL_W-1:0]   ecol_q;
	logic                          elast_q;
	logic [bmf2d_pkg::KSIZE_W-1:0] dr_q, dc_q;
	logic [bmf2d_pkg::SUM_W-1:0]   sum_q;

	// divider
	logic [bmf2d_pkg::NUM_W-1:0]  quo_q;
	logic [bmf2d_pkg::N_W-1:0]    rem_q;
	logic [bmf2d_pkg::DCNT_W-1:0] cnt_q;

	// output register
	logic                         out_valid_q;
	logic [bmf2d_pkg::MEAN_W-1:0] mean_q;
	logic                         frame_end_q;

	// line store
	logic [bmf2d_pkg::PIX_W-1:0] line_mem [bmf2d_pkg::MEM_DEPTH];
	logic [bmf2d_pkg::PIX_W-1:0] rd_data_s1;
	logic                        rd_ok_s1;

	// effective configuration
	logic [bmf2d_pkg::KSIZE_W-1:0]  k_eff, k_m1;
	logic [bmf2d_pkg::WIDTH_W-1:0]  w_eff;
	logic [bmf2d_pkg::HEIGHT_W-1:0] h_eff;
	logic [bmf2d_pkg::COL_W:0]      w_lim;
	logic [bmf2d_pkg::ROW_W:0]      h_lim;
	logic [bmf2d_pkg::R_W-1:0]      rad;
	logic [bmf2d_pkg::LAG_W-1:0]    lag;
	logic [bmf2d_pkg::N_W-1:0]      n_area;

	// accept-cycle values
	logic                        in_fire, cfg_fire, restart_pre, emit, last;
	logic [bmf2d_pkg::ROW_W-1:0] irow_pre, orow_pre;
	logic [bmf2d_pkg::COL_W-1:0] icol_pre, ocol_pre;
	logic [bmf2d_pkg::LAG_W-1:0] lead_pre;
	logic [bmf2d_pkg::COL_W:0]   icol_inc, ocol_inc;
	logic [bmf2d_pkg::ROW_W:0]   irow_inc, orow_inc;

	// window tap address
	logic [bmf2d_pkg::ROW_W+1:0] tap_row;
	logic [bmf2d_pkg::COL_W+1:0] tap_col;
	logic                        tap_ok, tap_last;
	logic                        mem_we;
	logic [bmf2d_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;

	// accumulate and divide
	logic [bmf2d_pkg::SUM_W-1:0] sum_nx;
	logic [bmf2d_pkg::NUM_W-1:0] numer;
	logic [bmf2d_pkg::N_W:0]     trial;
	logic                        trial_ge;
	logic [bmf2d_pkg::N_W-1:0]   rem_nx;

	// effective window, size and latency
	assign k_eff  = bmf2d_pkg::eff_kernel(kernel_size_q);
	assign k_m1   = k_eff - bmf2d_pkg::KSIZE_W'(1);
	assign w_eff  = bmf2d_pkg::eff_width(image_width_q);
	assign h_eff  = bmf2d_pkg::eff_height(image_height_q);
	assign w_lim  = (bmf2d_pkg::COL_W + 1)'(w_eff);
	assign h_lim  = (bmf2d_pkg::ROW_W + 1)'(h_eff);
	assign rad    = bmf2d_pkg::R_W'(k_m1 >> 1);
	assign lag    = bmf2d_pkg::LAG_W'(rad) * bmf2d_pkg::LAG_W'(w_lim) + bmf2d_pkg::LAG_W'(rad);
	assign n_area = bmf2d_pkg::N_W'(k_eff) * bmf2d_pkg::N_W'(k_eff);

	// handshakes
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign cfg_fire = cfg_write_en && ((cfg_index == bmf2d_pkg::REG_KERNEL_SIZE) ||
		(cfg_index == bmf2d_pkg::REG_IMAGE_WIDTH) || (cfg_index == bmf2d_pkg::REG_IMAGE_HEIGHT));

	// a pixel after a complete frame starts a new one
	assign restart_pre = (command == bmf2d_pkg::CMD_PIXEL) && done_q;
	assign irow_pre    = restart_pre ? '0 : irow_q;
	assign icol_pre    = restart_pre ? '0 : icol_q;
	assign orow_pre    = restart_pre ? '0 : orow_q;
	assign ocol_pre    = restart_pre ? '0 : ocol_q;
	assign lead_pre    = restart_pre ? '0 : lead_q;

	assign icol_inc = {1'b0, icol_pre} + (bmf2d_pkg::COL_W + 1)'(1);
	assign irow_inc = {1'b0, irow_pre} + (bmf2d_pkg::ROW_W + 1)'(1);
	assign ocol_inc = {1'b0, ocol_pre} + (bmf2d_pkg::COL_W + 1)'(1);
	assign orow_inc = {1'b0, orow_pre} + (bmf2d_pkg::ROW_W + 1)'(1);

	// a result is due once the window's lower half has arrived, or on flush after the frame
	assign emit = (command == bmf2d_pkg::CMD_PIXEL) ? (lead_pre == lag) : done_q;
	assign last = ({1'b0, orow_pre} == h_lim - (bmf2d_pkg::ROW_W + 1)'(1)) &&
		({1'b0, ocol_pre} == w_lim - (bmf2d_pkg::COL_W + 1)'(1));

	// window tap position, padding masked
	assign tap_row  = (bmf2d_pkg::ROW_W + 2)'(erow_q) + (bmf2d_pkg::ROW_W + 2)'(dr_q) -
		(bmf2d_pkg::ROW_W + 2)'(rad);
	assign tap_col  = (bmf2d_pkg::COL_W + 2)'(ecol_q) + (bmf2d_pkg::COL_W + 2)'(dc_q) -
		(bmf2d_pkg::COL_W + 2)'(rad);
	assign tap_ok   = (state_q == S_READ) &&
		!tap_row[bmf2d_pkg::ROW_W+1] && (tap_row[bmf2d_pkg::ROW_W:0] < h_lim) &&
		!tap_col[bmf2d_pkg::COL_W+1] && (tap_col[bmf2d_pkg::COL_W:0] < w_lim);
	assign tap_last = (dr_q == k_m1) && (dc_q == k_m1);

	// line store ports
	assign mem_we    = in_fire && !cfg_fire && (command == bmf2d_pkg::CMD_PIXEL);
	assign mem_waddr = {irow_pre[bmf2d_pkg::RING_W-1:0], icol_pre};
	assign mem_raddr = {tap_row[bmf2d_pkg::RING_W-1:0], tap_col[bmf2d_pkg::COL_W-1:0]};

	// running window sum and rounded numerator
	assign sum_nx = sum_q + (rd_ok_s1 ? bmf2d_pkg::SUM_W'(rd_data_s1) : '0);
	assign numer  = {sum_nx, 8'b0} + bmf2d_pkg::NUM_W'(n_area >> 1);

	// one restoring divide step
	assign trial    = {rem_q, quo_q[bmf2d_pkg::NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, n_area});
	assign rem_nx   = trial_ge ? bmf2d_pkg::N_W'(trial - {1'b0, n_area}) : trial[bmf2d_pkg::N_W-1:0];

	// line store memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_waddr] <= pixel_value;
		end
		rd_data_s1 <= line_mem[mem_raddr];
	end

	// sequencer, frame counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			kernel_size_q  <= bmf2d_pkg::KSIZE_RST;
			image_width_q  <= bmf2d_pkg::WIDTH_RST;
			image_height_q <= bmf2d_pkg::HEIGHT_RST;
			irow_q         <= '0;
			icol_q         <= '0;
			orow_q         <= '0;
			ocol_q         <= '0;
			lead_q         <= '0;
			done_q         <= 1'b0;
			erow_q         <= '0;
			ecol_q         <= '0;
			elast_q        <= 1'b0;
			dr_q           <= '0;
			dc_q           <= '0;
			sum_q          <= '0;
			rd_ok_s1       <= 1'b0;
			quo_q          <= '0;
			rem_q          <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			mean_q         <= '0;
			frame_end_q    <= 1'b0;
		end else begin
			// output word taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_ok_s1 <= tap_ok;
			sum_q    <= sum_nx;

			if (cfg_fire) begin
				// register write restarts the frame
				case (cfg_index)
					bmf2d_pkg::REG_KERNEL_SIZE:  kernel_size_q  <= cfg_data[bmf2d_pkg::KSIZE_W-1:0];
					bmf2d_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[bmf2d_pkg::WIDTH_W-1:0];
					bmf2d_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[bmf2d_pkg::HEIGHT_W-1:0];
					default: ;
				endcase
				irow_q <= '0;
				icol_q <= '0;
				orow_q <= '0;
				ocol_q <= '0;
				lead_q <= '0;
				done_q <= 1'b0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_fire) begin
							// pixel: advance input position
							if (command == bmf2d_pkg::CMD_PIXEL) begin
								orow_q <= orow_pre;
								ocol_q <= ocol_pre;
								lead_q <= (lead_pre < lag) ? lead_pre + bmf2d_pkg::LAG_W'(1) : lead_pre;
								done_q <= 1'b0;
								if (icol_inc >= w_lim) begin
									icol_q <= '0;
									if (irow_inc >= h_lim) begin
										irow_q <= '0;
										done_q <= 1'b1;
									end else begin
										irow_q <= irow_inc[bmf2d_pkg::ROW_W-1:0];
									end
								end else begin
									irow_q <= irow_pre;
									icol_q <= icol_inc[bmf2d_pkg::COL_W-1:0];
								end
							end
							// result due: latch its position and start the window walk
							if (emit) begin
								erow_q  <= orow_pre;
								ecol_q  <= ocol_pre;
								elast_q <= last;
								dr_q    <= '0;
								dc_q    <= '0;
								sum_q   <= '0;
								state_q <= S_READ;
								if (last) begin
									irow_q <= '0;
									icol_q <= '0;
									orow_q <= '0;
									ocol_q <= '0;
									lead_q <= '0;
									done_q <= 1'b0;
								end else if (ocol_inc >= w_lim) begin
									ocol_q <= '0;
									orow_q <= orow_inc[bmf2d_pkg::ROW_W-1:0];
								end else begin
									orow_q <= orow_pre;
									ocol_q <= ocol_inc[bmf2d_pkg::COL_W-1:0];
								end
							end
						end
					end
					S_READ: begin
						// one window tap per cycle
						if (tap_last) begin
							state_q <= S_ACC;
						end else if (dc_q == k_m1) begin
							dc_q <= '0;
							dr_q <= dr_q + bmf2d_pkg::KSIZE_W'(1);
						end else begin
							dc_q <= dc_q + bmf2d_pkg::KSIZE_W'(1);
						end
					end
					S_ACC: begin
						// last tap lands, load divider
						quo_q   <= numer;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
					S_DIV: begin
						quo_q <= {quo_q[bmf2d_pkg::NUM_W-2:0], trial_ge};
						rem_q <= rem_nx;
						cnt_q <= cnt_q + bmf2d_pkg::DCNT_W'(1);
						if (cnt_q == bmf2d_pkg::DCNT_W'(bmf2d_pkg::NUM_W - 1)) begin
							state_q <= S_OUT;
						end
					end
					S_OUT: begin
						// wait for a free output register
						if (!out_valid_q || out_ready) begin
							out_valid_q <= 1'b1;
							mean_q      <= quo_q[bmf2d_pkg::MEAN_W-1:0];
							frame_end_q <= elast_q;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign mean_q8   = mean_q;
	assign frame_end = frame_end_q;

endmodule

// ----- sv/bmf2d_checker.sv -----
// bmf2d_assertions: port-level assertions for box_mean_filter_2d, plus its bind.
// Depends on bmf2d_pkg.
module bmf2d_assertions (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bmf2d_pkg::MEAN_W-1:0] mean_q8,
	input logic                         frame_end
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_q8) && $stable(frame_end))
		else $error("output word changed while stalled");

	// a mean never exceeds 255.0
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mean_q8 <= bmf2d_pkg::MEAN_MAX)
		else $error("mean out of range");

	// a new result appears only after the block stopped taking input words
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output word appeared while input was open");

endmodule

bind box_mean_filter_2d bmf2d_assertions u_bmf2d_assertions (.*);
